// ===== rtl/core/sti_pkg.sv =====
package sti_pkg;

  localparam logic [1:0] CMD_TEST = 2'd3;
  localparam int unsigned NUM_STEPS = 39;

  typedef enum logic [2:0] {
    PT_V0,
    PT_V1,
    PT_V2,
    PT_A,
    PT_B
  } pt_t;

  // one multiply-accumulate step: x operand is a difference or a stored cross
  // component, y operand is always a difference of two points
  typedef struct packed {
    logic       go;
    logic       x_c;
    pt_t        xp;
    pt_t        xq;
    logic [1:0] xk;
    pt_t        yp;
    pt_t        yq;
    logic [1:0] yk;
    logic       clr;
    logic       neg;
    logic       wr_c;
    logic [1:0] wk;
    logic       sg;
    logic [2:0] sk;
  } mac_op_t;

  typedef struct packed {
    logic       ld_v;
    logic       ld_ab;
    logic [1:0] v_idx;
  } ld_ctl_t;

  typedef struct packed {
    logic hit;
  } dp_stat_t;

  // plane side tests: n = e1 x e2, then (V0-A).n and (B-V0).n;
  // then three groups of cross(Wi,Wj) followed by its dot with B-A
  function automatic mac_op_t mac_decode(logic [5:0] step);
    mac_op_t    op;
    logic [5:0] rel;
    logic [5:0] r;
    logic [1:0] grp;
    logic       is_cross;
    pt_t        pp, pq, qp, qq, dp, dq;
    logic [2:0] sk;
    logic [1:0] k, i, l;
    op       = '0;
    op.go    = 1'b1;
    rel      = '0;
    grp      = '0;
    is_cross = 1'b0;
    pp = PT_V0; pq = PT_V0; qp = PT_V0; qq = PT_V0; dp = PT_V0; dq = PT_V0;
    sk = '0;
    if (step < 6'd12) begin
      if (step < 6'd6) begin
        is_cross = 1'b1;
        r  = step;
        pp = PT_V1; pq = PT_V0; qp = PT_V2; qq = PT_V0;
      end else if (step < 6'd9) begin
        r  = step - 6'd6;
        dp = PT_V0; dq = PT_A; sk = 3'd0;
      end else begin
        r  = step - 6'd9;
        dp = PT_B; dq = PT_V0; sk = 3'd1;
      end
    end else begin
      rel = step - 6'd12;
      if (rel >= 6'd18) grp = 2'd2;
      else if (rel >= 6'd9) grp = 2'd1;
      else grp = 2'd0;
      r = rel - 6'(grp) * 6'd9;
      unique case (grp)
        2'd0: begin pp = PT_V0; qp = PT_V1; end
        2'd1: begin pp = PT_V1; qp = PT_V2; end
        default: begin pp = PT_V2; qp = PT_V0; end
      endcase
      pq = PT_A;
      qq = PT_A;
      if (r < 6'd6) begin
        is_cross = 1'b1;
      end else begin
        r  = r - 6'd6;
        dp = PT_B; dq = PT_A; sk = 3'd2 + 3'(grp);
      end
    end
    if (is_cross) begin
      k = r[2:1];
      i = (k == 2'd2) ? 2'd0 : k + 2'd1;
      l = (k == 2'd0) ? 2'd2 : k - 2'd1;
      op.xp = pp; op.xq = pq; op.yp = qp; op.yq = qq;
      if (!r[0]) begin
        op.xk  = i;
        op.yk  = l;
        op.clr = 1'b1;
      end else begin
        op.xk   = l;
        op.yk   = i;
        op.neg  = 1'b1;
        op.wr_c = 1'b1;
        op.wk   = k;
      end
    end else begin
      op.x_c = 1'b1;
      op.xk  = r[1:0];
      op.yp  = dp;
      op.yq  = dq;
      op.yk  = r[1:0];
      op.clr = (r == 6'd0);
      op.sg  = (r == 6'd2);
      op.sk  = sk;
    end
    return op;
  endfunction

endpackage

// ===== rtl/core/sti_datapath.sv =====
module sti_datapath
  import sti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ld_ctl_t                      ld,
  input  mac_op_t                      op,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  output dp_stat_t                     stat
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int XW = 2 * CB + 3;
  localparam int PW = XW + DW;
  localparam int AW = 3 * CB + 6;

  logic signed [CB-1:0] v [3][3];
  logic signed [CB-1:0] a [3];
  logic signed [CB-1:0] b [3];
  logic signed [XW-1:0] c [3];

  logic signed [PW-1:0] prod;
  logic                 p_vld;
  logic                 p_clr, p_neg, p_wr_c, p_sg;
  logic [1:0]           p_wk;
  logic [2:0]           p_sk;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc_next;
  logic [4:0]           s_neg;
  logic [4:0]           s_nz;

  logic signed [DW-1:0] xd, yd;
  logic signed [XW-1:0] opx;

  function automatic logic signed [CB-1:0] coord(pt_t p, logic [1:0] k);
    logic signed [CB-1:0] r;
    r = '0;
    if (k != 2'd3) begin
      unique case (p)
        PT_V0:   r = v[0][k];
        PT_V1:   r = v[1][k];
        PT_V2:   r = v[2][k];
        PT_A:    r = a[k];
        PT_B:    r = b[k];
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    xd       = DW'(coord(op.xp, op.xk)) - DW'(coord(op.xq, op.xk));
    yd       = DW'(coord(op.yp, op.yk)) - DW'(coord(op.yq, op.yk));
    opx      = op.x_c ? c[op.xk] : XW'(xd);
    term     = p_neg ? -AW'(prod) : AW'(prod);
    acc_next = p_clr ? term : acc + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          v[i][k] <= '0;
        end
      end
      p_vld <= 1'b0;
    end else begin
      if (ld.ld_v && ld.v_idx != CMD_TEST) begin
        v[ld.v_idx][0] <= ax;
        v[ld.v_idx][1] <= ay;
        v[ld.v_idx][2] <= az;
      end
      p_vld <= op.go;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_ab) begin
      a[0] <= ax; a[1] <= ay; a[2] <= az;
      b[0] <= bx; b[1] <= by; b[2] <= bz;
    end
    // register the product before it reaches the accumulator
    prod   <= opx * yd;
    p_clr  <= op.clr;
    p_neg  <= op.neg;
    p_wr_c <= op.wr_c;
    p_wk   <= op.wk;
    p_sg   <= op.sg;
    p_sk   <= op.sk;
    if (p_vld) begin
      acc <= acc_next;
      if (p_wr_c && p_wk != 2'd3) c[p_wk] <= XW'(acc_next);
      if (p_sg && p_sk < 3'd5) begin
        s_neg[p_sk] <= acc_next[AW-1];
        s_nz[p_sk]  <= (acc_next != '0);
      end
    end
  end

  assign stat.hit = s_nz[0] && s_nz[1] && (s_neg[0] == s_neg[1]) &&
                    s_nz[2] && s_nz[3] && s_nz[4] &&
                    (s_neg[2] == s_neg[3]) && (s_neg[3] == s_neg[4]);

endmodule

// ===== rtl/core/sti_ctrl.sv =====
module sti_ctrl
  import sti_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       hit,
  output ld_ctl_t    ld,
  output mac_op_t    op,
  input  dp_stat_t   stat
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN,
    FINISH
  } state_t;

  state_t     state;
  logic [5:0] step;
  logic       accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ld.ld_v  = accept && (cmd != CMD_TEST);
    ld.ld_ab = accept && (cmd == CMD_TEST);
    ld.v_idx = cmd;
    op       = mac_decode(step);
    op.go    = (state == RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      // FINISH owns out_valid while it is waiting to hand over a result
      if (out_valid && out_ready && state != FINISH) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          step <= '0;
          if (accept && cmd == CMD_TEST) state <= RUN;
        end
        RUN: begin
          if (step == 6'(NUM_STEPS - 1)) begin
            step  <= '0;
            state <= DRAIN;
          end else begin
            step <= step + 6'd1;
          end
        end
        DRAIN: begin
          // let the product and accumulate stages settle
          if (step == 6'd1) state <= FINISH;
          step <= step + 6'd1;
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit       <= stat.hit;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/segment_triangle_intersect.sv =====
// Segment/triangle crossing test on one shared multiply-accumulate unit.
// Load beats (cmd 0..2) leave the block idle; the next beat may follow at once.
// A test beat runs 39 multiply steps, then lets the product and accumulate registers
// settle; hit and out_valid are registered as the block returns to idle for a new beat.
// The result sits in an output register, so a stalled consumer stalls only the next test.
// Synchronous reset clears the vertex store to zero and the handshake state.
module segment_triangle_intersect
  import sti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit
);

  ld_ctl_t  ld;
  mac_op_t  op;
  dp_stat_t stat;

  sti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .ld        (ld),
    .op        (op),
    .stat      (stat)
  );

  sti_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ld   (ld),
    .op   (op),
    .ax   (ax),
    .ay   (ay),
    .az   (az),
    .bx   (bx),
    .by   (by),
    .bz   (bz),
    .stat (stat)
  );

endmodule

// ===== rtl/core/sti_checker.sv =====
module sti_checker
  import sti_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic       hit
);

  // a load beat never blocks the next beat
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd != CMD_TEST |=> in_ready)
    else $error("input stalled after a load beat");

  // a test beat occupies the block
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_TEST |=> !in_ready)
    else $error("input taken while a test is in progress");

  // no result can appear straight after a test beat
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_TEST |=> !$rose(out_valid))
    else $error("result appeared too early");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit))
    else $error("stalled result dropped or changed");

endmodule

bind segment_triangle_intersect sti_checker u_sti_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sti_pkg::*;

  localparam int CB = 16;
  localparam int STALL_LIMIT = 4000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           cmd;
  logic signed [CB-1:0] ax, ay, az, bx, by, bz;
  logic                 out_valid;
  logic                 out_ready;
  logic                 hit;

  bit     hit_q[$];
  longint tri_v[3][3];
  int     n_fail;
  int     n_tests;
  int     n_hits;
  int     n_loads;
  int     stall_cnt;
  bit     calm;

  segment_triangle_intersect #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int sgn(longint v);
    return (v < 0) ? -1 : ((v != 0) ? 1 : 0);
  endfunction

  function automatic longint triple(longint p[3], longint q[3], longint d[3]);
    return d[0] * (p[1] * q[2] - p[2] * q[1]) +
           d[1] * (p[2] * q[0] - p[0] * q[2]) +
           d[2] * (p[0] * q[1] - p[1] * q[0]);
  endfunction

  // exact sign tests: strict side-of-plane, then strict barycentric inside
  function automatic bit crossing_hit(longint a[3], longint b[3]);
    longint e1[3], e2[3], dd[3], w0[3], w1[3], w2[3], bk[3], n[3];
    longint s_front, s_back;
    int t0, t1, t2;
    for (int k = 0; k < 3; k++) begin
      e1[k] = tri_v[1][k] - tri_v[0][k];
      e2[k] = tri_v[2][k] - tri_v[0][k];
      dd[k] = b[k] - a[k];
      w0[k] = tri_v[0][k] - a[k];
      w1[k] = tri_v[1][k] - a[k];
      w2[k] = tri_v[2][k] - a[k];
      bk[k] = b[k] - tri_v[0][k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s_front = w0[0] * n[0] + w0[1] * n[1] + w0[2] * n[2];
    s_back  = bk[0] * n[0] + bk[1] * n[1] + bk[2] * n[2];
    if (sgn(s_front) == 0 || sgn(s_front) != sgn(s_back)) return 1'b0;
    t0 = sgn(triple(w0, w1, dd));
    t1 = sgn(triple(w1, w2, dd));
    t2 = sgn(triple(w2, w0, dd));
    return (t0 != 0) && (t0 == t1) && (t1 == t2);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    n_fail++;
  endtask

  // predict on each accepted test beat, check each result beat
  always @(posedge clk) begin
    longint a[3], b[3];
    bit     exp_hit;
    if (!rst) begin
      if (in_valid && in_ready) begin
        a[0] = ax; a[1] = ay; a[2] = az;
        b[0] = bx; b[1] = by; b[2] = bz;
        if (cmd == CMD_TEST) begin
          hit_q.push_back(crossing_hit(a, b));
          n_tests++;
        end else begin
          for (int k = 0; k < 3; k++) tri_v[cmd][k] = a[k];
          n_loads++;
        end
      end
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_hit = hit_q.pop_front();
          if (hit !== exp_hit)
            report_mismatch($sformatf("hit %b, expected %b", hit, exp_hit));
          if (hit === 1'b1) n_hits++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("segment_triangle_intersect regression: fail");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(logic [1:0] c, int pa0, int pa1, int pa2,
                           int pb0 = 0, int pb1 = 0, int pb2 = 0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    ax <= pa0[CB-1:0]; ay <= pa1[CB-1:0]; az <= pa2[CB-1:0];
    bx <= pb0[CB-1:0]; by <= pb1[CB-1:0]; bz <= pb2[CB-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                          int x2, int y2, int z2);
    send_item(2'd0, x0, y0, z0, $urandom, $urandom, $urandom);
    send_item(2'd1, x1, y1, z1, $urandom, $urandom, $urandom);
    send_item(2'd2, x2, y2, z2, $urandom, $urandom, $urandom);
  endtask

  task automatic test_reset_store();
    send_item(CMD_TEST, 10, 10, 100, 10, 10, -100);
    send_item(CMD_TEST, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_special_cases();
    load_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_item(CMD_TEST, 64, 64, 256, 64, 64, -256);   // clean crossing
    send_item(CMD_TEST, 64, 64, -256, 64, 64, 256);   // reverse direction
    send_item(CMD_TEST, 0, 0, 10, 200, 200, 10);      // parallel
    send_item(CMD_TEST, 64, 64, 5, 64, 64, 5);        // zero length
    send_item(CMD_TEST, 64, 64, 0, 64, 64, -256);     // end on plane
    send_item(CMD_TEST, 128, 0, 256, 128, 0, -256);   // through an edge
    send_item(CMD_TEST, 0, 0, 256, 0, 0, -256);       // through a vertex
    send_item(CMD_TEST, 300, 300, 256, 300, 300, -256); // outside
    send_item(CMD_TEST, 64, 64, 256, 64, 64, 100);    // same side
    load_tri(0, 0, 0, 100, 100, 100, 200, 200, 200);  // collinear
    send_item(CMD_TEST, 50, 0, 256, 50, 0, -256);
    load_tri(-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0);
    send_item(CMD_TEST, 0, 0, 32767, 0, 0, -32768);
    send_item(CMD_TEST, 32767, 32767, 32767, -32768, -32768, -32768);
    load_tri(32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768);
    send_item(CMD_TEST, 0, 0, 32767, 0, 0, -32768);
    send_item(CMD_TEST, -32768, -32768, -32768, 32767, 32767, 32767);
  endtask

  function automatic int rnd_coord(int span);
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 65535)) - 32768;
      1: return ($urandom_range(0, 1)) ? 32767 : -32768;
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  task automatic test_random(int n_items);
    int sent, span, ntest;
    int v[3][3];
    sent = 0;
    while (sent < n_items) begin
      if (sent > n_items - 300) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        // noise: any command, any coordinates
        send_item(2'($urandom_range(0, 3)), rnd_coord(32768), rnd_coord(32768),
                  rnd_coord(32768), rnd_coord(32768), rnd_coord(32768),
                  rnd_coord(32768));
        sent++;
      end else begin
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(4, 2000);
        for (int i = 0; i < 3; i++) begin
          v[i][0] = $signed($urandom_range(0, 2 * span)) - span;
          v[i][1] = $signed($urandom_range(0, 2 * span)) - span;
          v[i][2] = $signed($urandom_range(0, span / 4)) - span / 8;
        end
        load_tri(v[0][0], v[0][1], v[0][2], v[1][0], v[1][1], v[1][2],
                 v[2][0], v[2][1], v[2][2]);
        sent += 3;
        ntest = $urandom_range(1, 5);
        for (int t = 0; t < ntest; t++) begin
          send_item(CMD_TEST,
                    $signed($urandom_range(0, 2 * span)) - span,
                    $signed($urandom_range(0, 2 * span)) - span,
                    $urandom_range(1, 32767),
                    $signed($urandom_range(0, 2 * span)) - span,
                    $signed($urandom_range(0, 2 * span)) - span,
                    -$signed($urandom_range(1, 32768)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    ax = '0; ay = '0; az = '0; bx = '0; by = '0; bz = '0;
    n_fail = 0; n_tests = 0; n_hits = 0; n_loads = 0; stall_cnt = 0;
    calm = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) tri_v[i][k] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_store();
    test_special_cases();
    test_random(1800);
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d vertex loads and %0d segment tests, %0d hits",
             n_loads, n_tests, n_hits);
    $display("mismatches: %0d", n_fail);
    if (n_fail == 0)
      $display("segment_triangle_intersect regression: pass");
    else
      $display("segment_triangle_intersect regression: fail");
    $finish;
  end

endmodule
